// File: hw/rtl/kmred_pkg.sv
package kmred_pkg;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } kmred_state_e;

  // Fixed keymap geometry and the function key position
  localparam int MapRows = 4;
  localparam int MapCols = 12;
  localparam int InCols  = 12;
  localparam int FnRow   = 3;
  localparam int FnCol   = 3;

  typedef logic [7:0] keycode_t;

  localparam keycode_t BASE_MAP [MapRows][MapCols] = '{
    '{8'd177, 8'd113, 8'd119, 8'd101, 8'd114, 8'd116,
      8'd121, 8'd117, 8'd105, 8'd111, 8'd112, 8'd178},
    '{8'd179, 8'd97,  8'd115, 8'd100, 8'd102, 8'd103,
      8'd104, 8'd106, 8'd107, 8'd108, 8'd59,  8'd39},
    '{8'd129, 8'd122, 8'd120, 8'd99,  8'd118, 8'd98,
      8'd110, 8'd109, 8'd44,  8'd46,  8'd47,  8'd176},
    '{8'd128, 8'd135, 8'd130, 8'd0,   8'd0,   8'd0,
      8'd32,  8'd0,   8'd216, 8'd217, 8'd218, 8'd215}
  };

  localparam keycode_t FN_MAP [MapRows][MapCols] = '{
    '{8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,
      8'd54,  8'd55,  8'd56,  8'd57,  8'd95,  8'd61},
    '{8'd179, 8'd97,  8'd115, 8'd100, 8'd102, 8'd103,
      8'd104, 8'd106, 8'd107, 8'd108, 8'd59,  8'd39},
    '{8'd129, 8'd122, 8'd120, 8'd99,  8'd118, 8'd98,
      8'd110, 8'd109, 8'd44,  8'd46,  8'd47,  8'd176},
    '{8'd128, 8'd135, 8'd130, 8'd0,   8'd0,   8'd0,
      8'd32,  8'd0,   8'd216, 8'd217, 8'd218, 8'd215}
  };

  // Keycode lookup; keys outside the map give 0
  function automatic keycode_t keycode(input logic fn_layer, input logic [3:0] row,
                                       input logic [4:0] col);
    keycode_t code;
    code = '0;
    if ((32'(row) < MapRows) && (32'(col) < MapCols)) begin
      code = fn_layer ? FN_MAP[row[1:0]][col[3:0]] : BASE_MAP[row[1:0]][col[3:0]];
    end
    return code;
  endfunction

endpackage

// File: hw/rtl/kmred_store.sv
module kmred_store #(
  parameter int ROWS = 4,
  parameter int COLS = 12,
  parameter int RW   = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [RW-1:0]   row_i,
  input  logic [COLS-1:0] wr_levels_i,
  output logic [COLS-1:0] rd_levels_o,
  output logic            fn_pressed_o
);
  import kmred_pkg::*;

  // Key levels, 1 = released
  logic [COLS-1:0] levels_q [ROWS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        levels_q[r] <= '1;
      end
    end else if (wr_en_i) begin
      levels_q[row_i] <= wr_levels_i;
    end
  end

  assign rd_levels_o = levels_q[row_i];

  // Function key, only when the matrix has that position
  if ((FnRow < ROWS) && (FnCol < COLS)) begin : g_fn
    assign fn_pressed_o = ~levels_q[FnRow][FnCol];
  end else begin : g_no_fn
    assign fn_pressed_o = 1'b0;
  end

endmodule

// File: hw/rtl/kmred_scan.sv
module kmred_scan #(
  parameter int COLS = 12,
  parameter int RW   = 2,
  parameter int CW   = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RW-1:0]       row_i,
  input  logic [COLS-1:0]     new_levels_i,
  input  logic [COLS-1:0]     old_levels_i,
  input  logic                fn_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_press_o,
  output kmred_pkg::keycode_t key_code_o,
  output logic [3:0]          column_o,
  output logic                last_event_o
);
  import kmred_pkg::*;

  kmred_state_e    state_q, state_d;
  logic [CW-1:0]   col_q;
  logic [COLS-1:0] diff_q, lev_q, diff_clr;
  logic [RW-1:0]   row_q;
  logic            fn_q;
  logic            slot_free, changed, emit, step, last;
  logic            out_valid_q;
  logic            is_press_q, last_q;
  keycode_t        code_q;
  logic [3:0]      column_q;

  // Current column and what remains after it
  always_comb begin
    diff_clr          = diff_q;
    diff_clr[col_q]   = 1'b0;
  end
  assign changed   = diff_q[col_q];
  assign last      = (diff_clr == '0);
  assign slot_free = ~out_valid_q | ~out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SCAN;
      ST_SCAN: if (emit && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy_o = 1'b0;
    emit   = 1'b0;
    step   = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_SCAN: begin
        busy_o = 1'b1;
        emit   = changed & slot_free;
        step   = ~changed | slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Row context and column walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      diff_q <= '0;
    end else if (start_i) begin
      col_q  <= '0;
      diff_q <= new_levels_i ^ old_levels_i;
    end else if (step) begin
      col_q  <= col_q + CW'(1);
      diff_q <= diff_clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lev_q <= new_levels_i;
      row_q <= row_i;
      fn_q  <= fn_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      is_press_q <= ~lev_q[col_q];
      code_q     <= keycode(fn_q, 4'(row_q), 5'(col_q));
      column_q   <= 4'(col_q);
      last_q     <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_press_o   = is_press_q;
  assign key_code_o   = code_q;
  assign column_o     = column_q;
  assign last_event_o = last_q;

endmodule

// File: hw/rtl/key_matrix_row_event_detector.sv
// Channel | Handshake                | Payload
// in      | in_valid_i / in_stall_o  | row_index_i, column_bits_i
// out     | out_valid_o / out_stall_i| is_press_o, key_code_o, column_o, last_event_o
//
// A row request is taken while the walk is idle; the key state of that row is updated
// at once and a column counter then walks one column per cycle, stopping after the last
// changed column. A row with no change, or an out-of-range row, ends at acceptance. Each
// event waits in the output register; a stalled output holds the walk on a changed
// column. in_stall_o is high while the walk runs.
// Reset clears the sequencer and sets every key to released.
module key_matrix_row_event_detector #(
  parameter int ROWS = 4,
  parameter int COLS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          row_index_i,
  input  logic [11:0]         column_bits_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_press_o,
  output kmred_pkg::keycode_t key_code_o,
  output logic [3:0]          column_o,
  output logic                last_event_o
);
  import kmred_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  logic            in_accept, row_ok, busy, fn_pressed, start;
  logic [RW-1:0]   row;
  logic [COLS-1:0] in_levels, old_levels;

  // Columns beyond the input read as released
  for (genvar c = 0; c < COLS; c++) begin : g_lev
    if (c < InCols) begin : g_in
      assign in_levels[c] = column_bits_i[c];
    end else begin : g_rel
      assign in_levels[c] = 1'b1;
    end
  end

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i & ~busy;
  assign row_ok     = (32'(row_index_i) < ROWS);
  assign row        = RW'(row_index_i);
  assign start      = in_accept & row_ok & (in_levels != old_levels);

  kmred_store #(
    .ROWS(ROWS),
    .COLS(COLS),
    .RW  (RW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_accept & row_ok),
    .row_i       (row),
    .wr_levels_i (in_levels),
    .rd_levels_o (old_levels),
    .fn_pressed_o(fn_pressed)
  );

  kmred_scan #(
    .COLS(COLS),
    .RW  (RW),
    .CW  (CW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .row_i       (row),
    .new_levels_i(in_levels),
    .old_levels_i(old_levels),
    .fn_i        (fn_pressed),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_press_o  (is_press_o),
    .key_code_o  (key_code_o),
    .column_o    (column_o),
    .last_event_o(last_event_o)
  );

endmodule

// File: bench/key_matrix_row_event_detector_checker.sv
module key_matrix_row_event_detector_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          row_index_i,
  input  logic [11:0]         column_bits_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                is_press_i,
  input  kmred_pkg::keycode_t key_code_i,
  input  logic [3:0]          column_i,
  input  logic                last_event_i,
  output int                  mismatches_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import kmred_pkg::*;

  typedef struct packed {
    logic       is_press;
    keycode_t   key_code;
    logic [3:0] column;
    logic       last_event;
  } key_event_t;

  // Shadow of the debounced key levels, 1 = released
  logic [11:0] key_levels [4];
  key_event_t  key_events_due [$];
  int          mismatch_count;

  // Compare the scanned row with the stored levels and queue the key events
  function automatic void scan_row(input logic [1:0] row, input logic [11:0] levels);
    logic       fn_layer;
    key_event_t row_events [$];
    key_event_t ev;
    fn_layer = !key_levels[FnRow][FnCol];
    for (int c = 0; c < 12; c++) begin
      if (levels[c] != key_levels[row][c]) begin
        ev.is_press   = !levels[c];
        ev.key_code   = fn_layer ? FN_MAP[row][c] : BASE_MAP[row][c];
        ev.column     = 4'(c);
        ev.last_event = 1'b0;
        row_events.push_back(ev);
      end
    end
    key_levels[row] = levels;
    if (row_events.size() > 0) begin
      row_events[row_events.size() - 1].last_event = 1'b1;
    end
    foreach (row_events[i]) begin
      key_events_due.push_back(row_events[i]);
    end
  endfunction

  // Check one emitted event against the oldest one due
  function automatic void check_key_event();
    key_event_t due;
    if (key_events_due.size() == 0) begin
      $error("unexpected key event: column %0d, key_code %0d", column_i, key_code_i);
      mismatch_count++;
      return;
    end
    due = key_events_due.pop_front();
    if (is_press_i !== due.is_press) begin
      $error("is_press: expected %0d, actual %0d", due.is_press, is_press_i);
      mismatch_count++;
    end
    if (key_code_i !== due.key_code) begin
      $error("key_code: expected %0d, actual %0d", due.key_code, key_code_i);
      mismatch_count++;
    end
    if (column_i !== due.column) begin
      $error("column: expected %0d, actual %0d", due.column, column_i);
      mismatch_count++;
    end
    if (last_event_i !== due.last_event) begin
      $error("last_event: expected %0d, actual %0d", due.last_event, last_event_i);
      mismatch_count++;
    end
  endfunction

  // Watch both channels; requests are predicted before events are checked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) key_levels[r] = '1;
      key_events_due.delete();
      mismatch_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) scan_row(row_index_i, column_bits_i);
      if (out_valid_i && !out_stall_i) check_key_event();
      mismatches_o <= mismatch_count;
      pending_o    <= key_events_due.size();
    end
  end

endmodule

// File: bench/key_matrix_row_event_detector_test.sv
module key_matrix_row_event_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kmred_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  row_index_i;
  logic [11:0] column_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        is_press_o;
  keycode_t    key_code_o;
  logic [3:0]  column_o;
  logic        last_event_o;
  int          mismatches;
  int          events_pending;

  // Levels last sent per row, used to shape key toggles
  logic [11:0] sent_levels [4];

  key_matrix_row_event_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .row_index_i   (row_index_i),
    .column_bits_i (column_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_press_o    (is_press_o),
    .key_code_o    (key_code_o),
    .column_o      (column_o),
    .last_event_o  (last_event_o)
  );

  key_matrix_row_event_detector_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .row_index_i   (row_index_i),
    .column_bits_i (column_bits_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_press_i    (is_press_o),
    .key_code_i    (key_code_o),
    .column_i      (column_o),
    .last_event_i  (last_event_o),
    .mismatches_o  (mismatches),
    .pending_o     (events_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("key_matrix_row_event_detector_test failed");
    $finish;
  end

  // Event sink backpressure: free runs, short jitter and rare long holds
  initial begin
    int pick;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk_i);
      end else if (pick < 93) begin
        out_stall_i <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(8, 30)) @(posedge clk_i);
      end
    end
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one row request and hold it until taken
  task automatic send_row(input logic [1:0] row, input logic [11:0] levels);
    int gap;
    in_valid_i    <= 1'b1;
    row_index_i   <= row;
    column_bits_i <= levels;
    do @(posedge clk_i); while (in_stall_o);
    sent_levels[row] = levels;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly a few keys changing on the row, plus repeats, extremes and noise
  function automatic logic [11:0] next_levels(input logic [1:0] row);
    logic [11:0] levels;
    int pick;
    levels = sent_levels[row];
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      repeat ($urandom_range(1, 3)) levels[$urandom_range(0, 11)] ^= 1'b1;
    end else if (pick < 65) begin
      levels = sent_levels[row];
    end else if (pick < 75) begin
      levels = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    end else begin
      levels = 12'($urandom_range(0, 4095));
    end
    return levels;
  endfunction

  initial begin
    logic [1:0] row;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    row_index_i   <= '0;
    column_bits_i <= '1;
    for (int r = 0; r < 4; r++) sent_levels[r] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no change, full rows, function layer on and off
    send_row(2'd0, 12'hFFF);
    send_row(2'd0, 12'h000);
    send_row(2'd0, 12'hFFF);
    send_row(2'd3, 12'hFF7);  // function key down, base map on this row
    send_row(2'd0, 12'h000);  // function layer
    send_row(2'd1, 12'h000);
    send_row(2'd2, 12'h000);
    send_row(2'd3, 12'hFFF);  // function key up, layer still active this row
    send_row(2'd0, 12'hFFF);  // releases on the base layer
    send_row(2'd3, 12'h000);
    send_row(2'd0, 12'hAAA);
    send_row(2'd0, 12'h555);
    send_row(2'd3, 12'hFFF);
    send_row(2'd0, 12'h555);  // no change
    send_row(2'd0, 12'hFFF);
    send_row(2'd1, 12'hFFF);
    send_row(2'd2, 12'h7FF);
    send_row(2'd2, 12'hFFE);
    send_row(2'd2, 12'hFFF);
    send_row(2'd3, 12'hFF7);
    send_row(2'd3, 12'hFF7);
    send_row(2'd3, 12'hFFF);

    // Random rows
    repeat (480) begin
      row = 2'($urandom_range(0, 3));
      send_row(row, next_levels(row));
    end
    in_valid_i <= 1'b0;

    // Drain, then let the walk settle
    do @(posedge clk_i); while (events_pending != 0);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0 && events_pending == 0) begin
      $display("key_matrix_row_event_detector_test passed");
    end else begin
      $display("key_matrix_row_event_detector_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/kmred_pkg.sv
hw/rtl/kmred_store.sv
hw/rtl/kmred_scan.sv
hw/rtl/key_matrix_row_event_detector.sv
bench/key_matrix_row_event_detector_checker.sv
bench/key_matrix_row_event_detector_test.sv
